>>> src/lruc_pkg.sv
// Shared constants, codes and control types for the sized LRU cache with locks.
package lruc_pkg;

  localparam int ENTRIES_DEF   = 256;
  localparam int SIZE_BITS_DEF = 20;

  localparam int ENTRY_W  = 8;
  localparam int BYTES_W  = 20;
  localparam int TOTAL_W  = 28;
  localparam int CNT_W    = 16;
  localparam int EVC_W    = 9;
  localparam int STATUS_W = 2;
  localparam int ERR_W    = 2;

  localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOC  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_QUEUED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LOCKED = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ABSENT   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNLOCKED = 2'd2;

  localparam logic KIND_FIND   = 1'b0;
  localparam logic KIND_UNLOCK = 1'b1;

  localparam logic [CNT_W-1:0] LOCK_MAX = '1;

  typedef struct packed {
    logic clear;
    logic accept;
    logic stage1;
    logic stage2;
    logic ev_apply;
    logic emit;
  } lruc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic ev_need;
    logic err;
    logic out_free;
  } lruc_sts_t;

endpackage

>>> src/lruc_if.sv
// Valid/ready channel interfaces for requests and results.
interface lruc_in_if;
  import lruc_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [ENTRY_W-1:0]  entry;
  logic                exists;
  logic                lock;
  logic                load_ok;
  logic [BYTES_W-1:0]  entry_bytes;
  modport source (output valid, kind, entry, exists, lock, load_ok, entry_bytes, input ready);
  modport sink (input valid, kind, entry, exists, lock, load_ok, entry_bytes, output ready);
endinterface

interface lruc_out_if;
  import lruc_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [STATUS_W-1:0] entry_status;
  logic [CNT_W-1:0]    lock_count;
  logic [TOTAL_W-1:0]  queued_bytes;
  logic [TOTAL_W-1:0]  locked_bytes;
  logic [EVC_W-1:0]    evicted_count;
  logic [ERR_W-1:0]    error_code;
  modport source (output valid, found, entry_status, lock_count, queued_bytes, locked_bytes,
                  evicted_count, error_code, input ready);
  modport sink (input valid, found, entry_status, lock_count, queued_bytes, locked_bytes,
                evicted_count, error_code, output ready);
endinterface

>>> src/sized_lru_cache_with_locks_top.sv
// Top level of the byte-budgeted LRU cache with entry locking.
// A request steps through read and update states, then an eviction check and one
// eviction step per entry evicted, unless it ends in an error, and then waits to
// emit. The controller steps one table access at a time through tables with one
// registered read port. The result waits in an output register while the next
// request starts. After reset a clearing pass zeroes the status and locker
// tables before the first request is taken; budget writes are taken at any time.
module sized_lru_cache_with_locks_top #(
  parameter int ENTRIES   = lruc_pkg::ENTRIES_DEF,
  parameter int SIZE_BITS = lruc_pkg::SIZE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lruc_in_if.sink                      in_ch,
  lruc_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [lruc_pkg::TOTAL_W-1:0] cfg_wdata
);
  import lruc_pkg::*;

  lruc_cmd_t cmd;
  lruc_sts_t sts;

  lruc_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .sts, .cmd
  );

  lruc_dp #(.ENTRIES(ENTRIES), .SIZE_BITS(SIZE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_wdata,
    .in_kind(in_ch.kind),
    .in_entry(in_ch.entry),
    .in_exists(in_ch.exists),
    .in_lock(in_ch.lock),
    .in_load_ok(in_ch.load_ok),
    .in_entry_bytes(in_ch.entry_bytes),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_found(out_ch.found),
    .out_entry_status(out_ch.entry_status),
    .out_lock_count(out_ch.lock_count),
    .out_queued_bytes(out_ch.queued_bytes),
    .out_locked_bytes(out_ch.locked_bytes),
    .out_evicted_count(out_ch.evicted_count),
    .out_error_code(out_ch.error_code)
  );
endmodule

>>> src/lruc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lruc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/lruc_ctrl.sv
// Controller state machine sequencing clear, lookup, update and eviction steps.
module lruc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lruc_pkg::lruc_sts_t sts,
  output lruc_pkg::lruc_cmd_t cmd
);
  import lruc_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_EVCHK = 3'd4;
  localparam logic [2:0] S_EVRD  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        cmd.stage1 = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        cmd.stage2 = 1'b1;
        state_nxt  = sts.err ? S_DONE : S_EVCHK;
      end
      S_EVCHK: begin
        state_nxt = sts.ev_need ? S_EVRD : S_DONE;
      end
      S_EVRD: begin
        cmd.ev_apply = 1'b1;
        state_nxt    = S_EVCHK;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

>>> src/lruc_dp.sv
// Datapath: entry tables, recency list links, byte totals and result register.
module lruc_dp #(
  parameter int ENTRIES   = lruc_pkg::ENTRIES_DEF,
  parameter int SIZE_BITS = lruc_pkg::SIZE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lruc_pkg::lruc_cmd_t           cmd,
  output lruc_pkg::lruc_sts_t           sts,
  input  logic                          cfg_we,
  input  logic [lruc_pkg::TOTAL_W-1:0]  cfg_wdata,
  input  logic                          in_kind,
  input  logic [lruc_pkg::ENTRY_W-1:0]  in_entry,
  input  logic                          in_exists,
  input  logic                          in_lock,
  input  logic                          in_load_ok,
  input  logic [lruc_pkg::BYTES_W-1:0]  in_entry_bytes,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [lruc_pkg::STATUS_W-1:0] out_entry_status,
  output logic [lruc_pkg::CNT_W-1:0]    out_lock_count,
  output logic [lruc_pkg::TOTAL_W-1:0]  out_queued_bytes,
  output logic [lruc_pkg::TOTAL_W-1:0]  out_locked_bytes,
  output logic [lruc_pkg::EVC_W-1:0]    out_evicted_count,
  output logic [lruc_pkg::ERR_W-1:0]    out_error_code
);
  import lruc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int EW = (IW > ENTRY_W) ? IW : ENTRY_W;
  localparam int BW = (SIZE_BITS > BYTES_W) ? SIZE_BITS : BYTES_W;
  localparam int SW = (SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W;

  function automatic logic [TOTAL_W-1:0] to_total(input logic [SIZE_BITS-1:0] s);
    logic [SW-1:0] t;
    t = SW'(s);
    return t[TOTAL_W-1:0];
  endfunction

  // request registers
  logic                 kind_r, lock_r, ok_r;
  logic [IW-1:0]        e_r;
  logic [SIZE_BITS-1:0] bytes_r;
  logic [ERR_W-1:0]     err_r, err_nxt;
  logic [STATUS_W-1:0]  st_r, st_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SIZE_BITS-1:0] sz_r, sz_nxt;
  // list and totals
  logic [IW-1:0]        head_r, head_nxt, tail_r, tail_nxt;
  logic                 empty_r, empty_nxt;
  logic [TOTAL_W-1:0]   qtot_r, qtot_nxt, ltot_r, ltot_nxt;
  logic [EVC_W-1:0]     evc_r, evc_nxt;
  logic [TOTAL_W-1:0]   budget_r;
  logic [IW-1:0]        clr_r;
  logic                 out_valid_r;

  // input decode
  logic [EW-1:0]        ent_ext;
  logic [BW-1:0]        bytes_ext;
  logic [IW-1:0]        idx_in;
  logic                 absent_in;

  assign ent_ext   = EW'(in_entry);
  assign bytes_ext = BW'(in_entry_bytes);
  assign idx_in    = ent_ext[IW-1:0];
  assign absent_in = !in_exists || (32'(ent_ext) >= 32'(ENTRIES));

  // memories
  logic                 st_we, cnt_we, sz_we, nw_we, od_we;
  logic [IW-1:0]        st_wa, cnt_wa, sz_wa, nw_wa, od_wa, raddr;
  logic [STATUS_W-1:0]  st_wd, st_rd;
  logic [CNT_W-1:0]     cnt_wd, cnt_rd;
  logic [SIZE_BITS-1:0] sz_rd;
  logic [IW-1:0]        nw_wd, od_wd, nw_rd, od_rd;

  assign raddr = cmd.accept ? idx_in : tail_r;

  lruc_ram #(.WIDTH(STATUS_W), .DEPTH(ENTRIES)) u_st_ram (
    .clk, .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr, .rdata(st_rd));
  lruc_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_cnt_ram (
    .clk, .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd), .raddr, .rdata(cnt_rd));
  lruc_ram #(.WIDTH(SIZE_BITS), .DEPTH(ENTRIES)) u_sz_ram (
    .clk, .we(sz_we), .waddr(sz_wa), .wdata(bytes_r), .raddr, .rdata(sz_rd));
  lruc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_nw_ram (
    .clk, .we(nw_we), .waddr(nw_wa), .wdata(nw_wd), .raddr, .rdata(nw_rd));
  lruc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_od_ram (
    .clk, .we(od_we), .waddr(od_wa), .wdata(od_wd), .raddr, .rdata(od_rd));

  logic [CNT_W-1:0] cnt2;
  logic             push;

  always_comb begin
    err_nxt   = err_r;
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    sz_nxt    = sz_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    qtot_nxt  = qtot_r;
    ltot_nxt  = ltot_r;
    evc_nxt   = evc_r;
    st_we = 1'b0; st_wa = e_r; st_wd = ST_NONE;
    cnt_we = 1'b0; cnt_wa = e_r; cnt_wd = '0;
    sz_we = 1'b0; sz_wa = e_r;
    nw_we = 1'b0; nw_wa = od_rd; nw_wd = nw_rd;
    od_we = 1'b0; od_wa = nw_rd; od_wd = od_rd;
    cnt2 = cnt_r;
    push = 1'b0;

    if (cmd.clear) begin
      st_we = 1'b1; st_wa = clr_r;
      cnt_we = 1'b1; cnt_wa = clr_r;
    end

    if (cmd.accept) begin
      err_nxt = absent_in ? ERR_ABSENT : ERR_NONE;
      evc_nxt = '0;
    end

    if (cmd.stage1) begin
      if (err_r != ERR_NONE) begin
        st_nxt  = ST_NONE;
        cnt_nxt = '0;
      end else if (kind_r == KIND_FIND) begin
        st_nxt  = st_rd;
        cnt_nxt = cnt_rd;
        sz_nxt  = sz_rd;
        if (st_rd == ST_NONE && ok_r) begin
          sz_nxt = bytes_r;
          st_nxt = ST_ALLOC;
          sz_we  = 1'b1;
        end else if (st_rd == ST_QUEUED) begin
          if (head_r == e_r && tail_r == e_r) begin
            empty_nxt = 1'b1;
            head_nxt  = '0;
            tail_nxt  = '0;
          end else if (head_r == e_r) begin
            head_nxt = od_rd;
          end else if (tail_r == e_r) begin
            tail_nxt = nw_rd;
          end else begin
            nw_we = 1'b1;
            od_we = 1'b1;
          end
          qtot_nxt = qtot_r - to_total(sz_rd);
          st_nxt   = ST_ALLOC;
        end
      end else if (st_rd != ST_LOCKED) begin
        err_nxt = ERR_UNLOCKED;
        st_nxt  = st_rd;
        cnt_nxt = cnt_rd;
      end else begin
        sz_nxt  = sz_rd;
        st_nxt  = ST_LOCKED;
        cnt_nxt = (cnt_rd != '0) ? cnt_rd - 1'b1 : '0;
        if (cnt_rd <= CNT_W'(1)) begin
          st_nxt   = ST_ALLOC;
          ltot_nxt = ltot_r - to_total(sz_rd);
        end
      end
    end

    if (cmd.stage2 && err_r == ERR_NONE) begin
      if (kind_r == KIND_FIND && lock_r) begin
        if (st_r == ST_ALLOC) begin
          st_nxt   = ST_LOCKED;
          cnt2     = '0;
          ltot_nxt = ltot_r + to_total(sz_r);
        end
        cnt_nxt = (cnt2 != LOCK_MAX) ? cnt2 + 1'b1 : cnt2;
      end else if (st_r == ST_ALLOC) begin
        push = 1'b1;
      end
      if (push) begin
        if (empty_r) begin
          tail_nxt  = e_r;
          empty_nxt = 1'b0;
        end else begin
          nw_we = 1'b1; nw_wa = head_r; nw_wd = e_r;
          od_we = 1'b1; od_wa = e_r;    od_wd = head_r;
        end
        head_nxt = e_r;
        qtot_nxt = qtot_r + to_total(sz_r);
        st_nxt   = ST_QUEUED;
      end
      st_we = 1'b1; st_wd = st_nxt;
      cnt_we = 1'b1; cnt_wd = cnt_nxt;
    end

    if (cmd.ev_apply) begin
      if (head_r == tail_r) begin
        empty_nxt = 1'b1;
        head_nxt  = '0;
        tail_nxt  = '0;
      end else begin
        tail_nxt = nw_rd;
      end
      qtot_nxt = qtot_r - to_total(sz_rd);
      evc_nxt  = evc_r + 1'b1;
      st_we = 1'b1; st_wa = tail_r; st_wd = ST_NONE;
      if (tail_r == e_r) st_nxt = ST_NONE;
    end
  end

  assign sts.clr_last = (clr_r == IW'(ENTRIES - 1));
  assign sts.ev_need  = (budget_r < qtot_r) && !empty_r;
  assign sts.err      = (err_r != ERR_NONE);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      qtot_r      <= '0;
      ltot_r      <= '0;
      budget_r    <= '1;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      err_r       <= ERR_NONE;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
      qtot_r  <= qtot_nxt;
      ltot_r  <= ltot_nxt;
      err_r   <= err_nxt;
      if (cmd.clear) clr_r <= clr_r + 1'b1;
      if (cfg_we) budget_r <= cfg_wdata;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r  <= st_nxt;
    cnt_r <= cnt_nxt;
    sz_r  <= sz_nxt;
    evc_r <= evc_nxt;
    if (cmd.accept) begin
      kind_r  <= in_kind;
      e_r     <= idx_in;
      lock_r  <= in_lock;
      ok_r    <= in_load_ok;
      bytes_r <= bytes_ext[SIZE_BITS-1:0];
    end
    if (cmd.emit) begin
      out_found         <= (st_r != ST_NONE);
      out_entry_status  <= st_r;
      out_lock_count    <= cnt_r;
      out_queued_bytes  <= qtot_r;
      out_locked_bytes  <= ltot_r;
      out_evicted_count <= evc_r;
      out_error_code    <= err_r;
    end
  end

  assign out_valid = out_valid_r;
endmodule

>>> src/lruc_checker.sv
// Port-level assertions for the cache top level and their bind.
module lruc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_found,
  input logic [lruc_pkg::STATUS_W-1:0] out_entry_status,
  input logic [lruc_pkg::CNT_W-1:0]    out_lock_count,
  input logic [lruc_pkg::EVC_W-1:0]    out_evicted_count,
  input logic [lruc_pkg::ERR_W-1:0]    out_error_code
);
  import lruc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_status)
      && $stable(out_lock_count) && $stable(out_error_code))
    else $error("result changed while stalled");

  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_found == (out_entry_status != ST_NONE))
    else $error("found disagrees with status");

  a_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == ERR_ABSENT |-> !out_found
      && out_lock_count == '0 && out_evicted_count == '0)
    else $error("absent entry reported state");

  a_unlock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == ERR_UNLOCKED |-> out_entry_status != ST_LOCKED
      && out_evicted_count == '0)
    else $error("bad unlock reported locked entry or eviction");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code == ERR_NONE || out_error_code == ERR_ABSENT
      || out_error_code == ERR_UNLOCKED)
    else $error("undefined error code");
endmodule

bind sized_lru_cache_with_locks_top lruc_checker u_lruc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_found(out_ch.found),
  .out_entry_status(out_ch.entry_status),
  .out_lock_count(out_ch.lock_count),
  .out_evicted_count(out_ch.evicted_count),
  .out_error_code(out_ch.error_code)
);
